// File: rtl/hcr_pkg.sv
`default_nettype none

package hcr_pkg;

	// Ramp shape
	localparam int PALETTE_SIZE  = 8;
	localparam int FRACTION_BITS = 8;
	localparam int SEG_W         = $clog2(PALETTE_SIZE);

	// Fixed field widths
	localparam int HEIGHT_W   = 16;
	localparam int DIFF_W     = HEIGHT_W + 1;
	localparam int REM_W      = HEIGHT_W;
	localparam int COLOR_W    = 32;
	localparam int CHAN_W     = 8;
	localparam int NUM_CHAN   = COLOR_W / CHAN_W;
	localparam int PAIR_W     = 2 * COLOR_W;
	localparam int NUM_PAIRS  = 4;
	localparam int NUM_COLORS = 2 * NUM_PAIRS;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = PAIR_W;

	// Divider pipeline: quotient bits resolved per stage
	localparam int STEPS_PER_STAGE = 2;
	localparam int DIV_STAGES      = (FRACTION_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
	// input stage + divider + map stage + output stage
	localparam int NUM_STAGES      = DIV_STAGES + 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEIGHT_MIN = 3'd0,
		REG_HEIGHT_MAX = 3'd1,
		REG_PAIR_0     = 3'd2,
		REG_PAIR_1     = 3'd3,
		REG_PAIR_2     = 3'd4,
		REG_PAIR_3     = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic               ovr;
		logic [COLOR_W-1:0] oc;
		logic               zero;
		logic               one;
		logic [REM_W-1:0]   rem;
		logic [REM_W-1:0]   span;
	} div_in_t;

	typedef struct packed {
		logic                     ovr;
		logic [COLOR_W-1:0]       oc;
		logic                     zero;
		logic                     one;
		logic [FRACTION_BITS-1:0] quo;
	} div_out_t;

endpackage

`default_nettype wire

// File: rtl/hcr_if.sv
`default_nettype none

interface hcr_point_if;
	logic                         valid;
	logic                         ready;
	logic [hcr_pkg::HEIGHT_W-1:0] height;
	logic                         has_override;
	logic [hcr_pkg::COLOR_W-1:0]  override_color;

	modport source (output valid, height, has_override, override_color, input ready);
	modport sink   (input valid, height, has_override, override_color, output ready);
endinterface

interface hcr_result_if;
	logic                        valid;
	logic                        ready;
	logic [hcr_pkg::COLOR_W-1:0] color;

	modport source (output valid, color, input ready);
	modport sink   (input valid, color, output ready);
endinterface

`default_nettype wire

// File: rtl/height_color_ramp.sv
// Pipeline: an accepted point word passes the input stage, four divider stages at two
//   quotient bits each, the palette map and the blend/output register to its color word.
// Throughput: one word per cycle; each stage moves on when the stage after it is free.
// Reset (arst_n low, asynchronous): pipeline emptied, height_min 0, height_max 255,
//   all palette colors 0. No clearing pass; a point can be taken right after reset.
`default_nettype none

module height_color_ramp (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [hcr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [hcr_pkg::CFG_DATA_W-1:0]   cfg_data,
	hcr_point_if.sink                             point,
	hcr_result_if.source                          result
);
	import hcr_pkg::*;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic signed [HEIGHT_W-1:0] height_min_q;
	logic signed [HEIGHT_W-1:0] height_max_q;
	logic        [PAIR_W-1:0]   pair_q [NUM_PAIRS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_min_q <= '0;
			height_max_q <= HEIGHT_W'(255);
			for (int i = 0; i < NUM_PAIRS; i++) begin
				pair_q[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_HEIGHT_MIN: height_min_q <= cfg_data[HEIGHT_W-1:0];
				REG_HEIGHT_MAX: height_max_q <= cfg_data[HEIGHT_W-1:0];
				REG_PAIR_0:     pair_q[0]    <= cfg_data;
				REG_PAIR_1:     pair_q[1]    <= cfg_data;
				REG_PAIR_2:     pair_q[2]    <= cfg_data;
				REG_PAIR_3:     pair_q[3]    <= cfg_data;
				default: ; // unused index, write dropped
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stall chain: a stage loads when it is empty or its word moves on
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3;
	logic en_s1, en_s2, en_s3;
	logic div_in_ready, div_out_valid;

	assign en_s3       = !v_s3 || result.ready;
	assign en_s2       = !v_s2 || en_s3;
	assign en_s1       = !v_s1 || div_in_ready;
	assign point.ready = en_s1;

	// ------------------------------------------------------------------
	// Stage 1: offset from height_min and span, both 17-bit signed
	// ------------------------------------------------------------------
	logic                       ovr_s1;
	logic [COLOR_W-1:0]         oc_s1;
	logic signed [DIFF_W-1:0]   diff_s1;
	logic signed [DIFF_W-1:0]   span_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= point.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			ovr_s1  <= point.has_override;
			oc_s1   <= point.override_color;
			diff_s1 <= DIFF_W'(signed'(point.height)) - DIFF_W'(height_min_q);
			span_s1 <= DIFF_W'(height_max_q) - DIFF_W'(height_min_q);
		end
	end

	// ------------------------------------------------------------------
	// Divider: n = (diff << FRACTION_BITS) / span, only meaningful for
	// 0 < diff < span. Outside that window the end flags decide n.
	// The rem/span words fit 16 bits inside that window.
	// ------------------------------------------------------------------
	div_in_t  div_in;
	div_out_t div_out;

	assign div_in = '{
		ovr:  ovr_s1,
		oc:   oc_s1,
		zero: (span_s1 <= 0) || (diff_s1 <= 0),
		one:  diff_s1 >= span_s1,
		rem:  diff_s1[REM_W-1:0],
		span: span_s1[REM_W-1:0]
	};

	hcr_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_ready  (div_in_ready),
		.in_word   (div_in),
		.out_valid (div_out_valid),
		.out_ready (en_s2),
		.out_word  (div_out)
	);

	// ------------------------------------------------------------------
	// Stage 2: segment / fraction and palette pick
	// ------------------------------------------------------------------
	localparam int SCALED_W = FRACTION_BITS + 1 + SEG_W;

	logic [COLOR_W-1:0]       color_pal [NUM_COLORS];
	logic [PAIR_W-1:0]        seg_pair  [PALETTE_SIZE];  // {upper neighbor, lower}
	logic [FRACTION_BITS:0]   n_val;
	logic [SCALED_W-1:0]      scaled;
	logic [SEG_W:0]           seg_full;
	logic [SEG_W-1:0]         seg;

	// per-segment neighbor pairs are fixed wiring, so one indexed read suffices;
	// the top segment pairs the last color with itself
	always_comb begin
		for (int i = 0; i < NUM_PAIRS; i++) begin
			color_pal[2*i]   = pair_q[i][COLOR_W-1:0];
			color_pal[2*i+1] = pair_q[i][PAIR_W-1:COLOR_W];
		end
		for (int s = 0; s < PALETTE_SIZE; s++) begin
			seg_pair[s] = {color_pal[(s + 1 < PALETTE_SIZE) ? s + 1 : PALETTE_SIZE - 1],
			               color_pal[s]};
		end
	end

	always_comb begin
		if (div_out.zero) begin
			n_val = '0;
		end else if (div_out.one) begin
			n_val = (FRACTION_BITS+1)'(1) << FRACTION_BITS;
		end else begin
			n_val = {1'b0, div_out.quo};
		end
		scaled   = SCALED_W'(n_val) * SCALED_W'(PALETTE_SIZE - 1);
		seg_full = scaled[SCALED_W-1:FRACTION_BITS];
		if (seg_full > (SEG_W+1)'(PALETTE_SIZE - 1)) begin
			seg = SEG_W'(PALETTE_SIZE - 1);
		end else begin
			seg = seg_full[SEG_W-1:0];
		end
	end

	logic                     ovr_s2;
	logic [COLOR_W-1:0]       oc_s2;
	logic [COLOR_W-1:0]       ca_s2;
	logic [COLOR_W-1:0]       cb_s2;
	logic [FRACTION_BITS-1:0] frac_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= div_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			ovr_s2  <= div_out.ovr;
			oc_s2   <= div_out.oc;
			ca_s2   <= seg_pair[seg][COLOR_W-1:0];
			cb_s2   <= seg_pair[seg][PAIR_W-1:COLOR_W];
			frac_s2 <= scaled[FRACTION_BITS-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: per-channel blend, override select, output register.
	// The step toward b never exceeds |b - a| since frac < 1, so the
	// channel stays inside 0..255 and needs no clamp.
	// ------------------------------------------------------------------
	localparam int PROD_W = FRACTION_BITS + CHAN_W;

	function automatic logic [CHAN_W-1:0] blend_chan(
		input logic [CHAN_W-1:0]        a,
		input logic [CHAN_W-1:0]        b,
		input logic [FRACTION_BITS-1:0] f
	);
		logic [CHAN_W-1:0] delta;
		logic [PROD_W-1:0] prod;
		logic [CHAN_W-1:0] step;
		delta = (b >= a) ? b - a : a - b;
		prod  = PROD_W'(f) * PROD_W'(delta);
		step  = prod[PROD_W-1:FRACTION_BITS];
		return (b >= a) ? a + step : a - step;
	endfunction

	logic [COLOR_W-1:0] blended;
	logic [COLOR_W-1:0] color_s3;

	always_comb begin
		for (int c = 0; c < NUM_CHAN; c++) begin
			blended[c*CHAN_W +: CHAN_W] = blend_chan(ca_s2[c*CHAN_W +: CHAN_W],
			                                         cb_s2[c*CHAN_W +: CHAN_W], frac_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			color_s3 <= ovr_s2 ? oc_s2 : blended;
		end
	end

	assign result.valid = v_s3;
	assign result.color = color_s3;

endmodule

`default_nettype wire

// File: rtl/hcr_div_pipe.sv
`default_nettype none

// Restoring divider, rem/span -> FRACTION_BITS quotient bits, two bits per stage.
// Requires rem < span. Each stage stalls only when it holds a word that cannot move.
module hcr_div_pipe (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire hcr_pkg::div_in_t in_word,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output hcr_pkg::div_out_t     out_word
);
	import hcr_pkg::*;

	typedef struct packed {
		div_in_t                  w;
		logic [FRACTION_BITS-1:0] quo;
	} stage_t;

	logic   v_sd    [DIV_STAGES];
	stage_t word_sd [DIV_STAGES];
	stage_t nxt     [DIV_STAGES];
	logic   [DIV_STAGES:0] en;

	function automatic stage_t div_step(input stage_t s);
		stage_t         r;
		logic [REM_W:0] rem2;
		logic           qb;
		r    = s;
		rem2 = {s.w.rem, 1'b0};
		qb   = rem2 >= {1'b0, s.w.span};
		if (qb) begin
			r.w.rem = REM_W'(rem2 - {1'b0, s.w.span});
		end else begin
			r.w.rem = rem2[REM_W-1:0];
		end
		r.quo = {s.quo[FRACTION_BITS-2:0], qb};
		return r;
	endfunction

	// backpressure chain, last stage first
	always_comb begin
		en[DIV_STAGES] = out_ready;
		for (int k = DIV_STAGES - 1; k >= 0; k--) begin
			en[k] = !v_sd[k] || en[k+1];
		end
	end

	assign in_ready = en[0];

	always_comb begin
		for (int k = 0; k < DIV_STAGES; k++) begin
			if (k == 0) begin
				nxt[k] = {in_word, FRACTION_BITS'(0)};
			end else begin
				nxt[k] = word_sd[k-1];
			end
			for (int j = 0; j < STEPS_PER_STAGE; j++) begin
				if (k * STEPS_PER_STAGE + j < FRACTION_BITS) begin
					nxt[k] = div_step(nxt[k]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_STAGES; k++) begin
				v_sd[k] <= 1'b0;
			end
		end else begin
			for (int k = 0; k < DIV_STAGES; k++) begin
				if (en[k]) begin
					v_sd[k] <= (k == 0) ? in_valid : v_sd[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < DIV_STAGES; k++) begin
			if (en[k]) begin
				word_sd[k] <= nxt[k];
			end
		end
	end

	assign out_valid = v_sd[DIV_STAGES-1];
	assign out_word  = '{
		ovr:  word_sd[DIV_STAGES-1].w.ovr,
		oc:   word_sd[DIV_STAGES-1].w.oc,
		zero: word_sd[DIV_STAGES-1].w.zero,
		one:  word_sd[DIV_STAGES-1].w.one,
		quo:  word_sd[DIV_STAGES-1].quo
	};

endmodule

`default_nettype wire

// File: rtl/hcr_checker.sv
`default_nettype none

module hcr_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        point_valid,
	input wire logic                        point_ready,
	input wire logic                        result_valid,
	input wire logic                        result_ready,
	input wire logic [hcr_pkg::COLOR_W-1:0] result_color
);
	import hcr_pkg::*;

	localparam int OCC_W = $clog2(NUM_STAGES + 1) + 1;

	// words in flight: accepted points not yet delivered
	logic [OCC_W-1:0] occ_q;
	logic             in_acc, out_acc;

	assign in_acc  = point_valid && point_ready;
	assign out_acc = result_valid && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (in_acc && !out_acc) begin
			occ_q <= occ_q + OCC_W'(1);
		end else if (out_acc && !in_acc) begin
			occ_q <= occ_q - OCC_W'(1);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_color))
		else $error("stalled color word changed or dropped");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(NUM_STAGES))
		else $error("more words in flight than pipeline stages");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> occ_q != '0)
		else $error("color word without an accepted point");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q == '0 |-> point_ready)
		else $error("empty pipeline refuses a point");

	a_reset: assert property (@(posedge clk)
		!arst_n |-> !result_valid)
		else $error("result valid during reset");

endmodule

bind height_color_ramp hcr_checker u_hcr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.point_valid  (point.valid),
	.point_ready  (point.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_color (result.color)
);

`default_nettype wire
